@@ sv/sbfd_pkg.sv @@
// Package: shared types and constants of the serial bridge FIFO device.
`default_nettype none
package sbfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned MODE_W   = 4;
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 48;
  localparam int unsigned ADDR_W   = 3;

  localparam logic [WORD_W-1:0] RECV_OK = 32'h0800_0000;
  localparam logic [WORD_W-1:0] READY   = 32'h0400_0000;
  localparam int unsigned RECV_SHIFT = 16;
  localparam int unsigned SEND_SHIFT = 20;

  localparam logic REG_IDENT = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_LED_OFF    = 4'd0,
    MODE_LED_ON     = 4'd1,
    MODE_INIT       = 4'd2,
    MODE_RECV       = 4'd3,
    MODE_SEND       = 4'd4,
    MODE_CHK_TX     = 4'd5,
    MODE_CHK_RX     = 4'd6,
    MODE_LINK_BYTE  = 4'd7,
    MODE_LINK_DRAIN = 4'd8,
    MODE_LINK_RESET = 4'd9
  } mode_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_POP_RX,
    ST_POP_TX
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage
`default_nettype wire

@@ sv/sbfd_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sbfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ sv/sbfd_fifo.sv @@
// Byte FIFO: head and fill count in flops, entries in a RAM.
`default_nettype none
module sbfd_fifo #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sbfd_pkg::fifo_req_t       req_i,
  input  wire logic [sbfd_pkg::BYTE_W-1:0] wdata_i,
  output logic      [sbfd_pkg::BYTE_W-1:0] rdata_o,
  output sbfd_pkg::fifo_stat_t           stat_o
);
  import sbfd_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [AW-1:0] head_q, head_d, head_nxt, waddr;
  logic [CW-1:0] count_q, count_d;
  logic [AW:0]   slot_sum;

  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);

  assign slot_sum = {1'b0, head_q} + (AW + 1)'(count_q);
  assign waddr    = (slot_sum >= (AW + 1)'(DEPTH)) ? AW'(slot_sum - (AW + 1)'(DEPTH))
                                                   : slot_sum[AW-1:0];
  assign head_nxt = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    priority if (req_i.clear) begin
      head_d  = '0;
      count_d = '0;
    end else if (req_i.push) begin
      count_d = count_q + 1'b1;
    end else if (req_i.pop) begin
      head_d  = head_nxt;
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  sbfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.push),
    .waddr_i (waddr),
    .wdata_i (wdata_i),
    .raddr_i (head_q),
    .rdata_o (rdata_o)
  );

endmodule
`default_nettype wire

@@ sv/serial_bridge_fifo_device_unit.sv @@
// Top level: bus/link bridge with receive and transmit byte FIFOs.
//
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+-------------------------------------
//  request  | in  | s_axis_tvalid/s_axis_tready | mode, bus_word, link_byte
//  result   | out | m_axis_tvalid/m_axis_tready | read_word, tx_valid, tx_byte, overflow
//  config   | in  | psel/penable/pwrite/pready  | ident_word at address 0
//
// A request that pops a FIFO byte (recv or link drain with data) passes a pop state
// that waits on the registered FIFO RAM read; every other request is answered directly.
// Reset clears the FIFO heads and counts and the ident word; no clearing pass.
// A link reset empties both FIFOs in its own cycle.
// A new request is taken while no pop waits on its RAM read and the result
// register is empty or being taken.
`default_nettype none
module serial_bridge_fifo_device_unit #(
  parameter int unsigned RX_DEPTH = 16,
  parameter int unsigned TX_DEPTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [3:0] mode, [35:4] bus_word, [43:36] link_byte, [47:44] zero
  input  wire logic [sbfd_pkg::S_DATA_W-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [31:0] read_word, [32] tx_valid, [40:33] tx_byte, [41] overflow, [47:42] zero
  output logic      [sbfd_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sbfd_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [sbfd_pkg::WORD_W-1:0]     pwdata,
  output logic      [sbfd_pkg::WORD_W-1:0]     prdata,
  output logic                                 pready
);
  import sbfd_pkg::*;

  state_e            state_q, state_d;
  logic [WORD_W-1:0] ident_q;
  logic              accept;
  mode_e             mode;
  logic [WORD_W-1:0] bus_word;
  logic [BYTE_W-1:0] link_byte;
  fifo_req_t         rx_req, tx_req;
  fifo_stat_t        rx_stat, tx_stat;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;

  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q, out_word_d;
  logic              out_txv_q, out_txv_d;
  logic [BYTE_W-1:0] out_txb_q, out_txb_d;
  logic              out_ovf_q, out_ovf_d;

  assign mode      = mode_e'(s_axis_tdata[MODE_W-1:0]);
  assign bus_word  = s_axis_tdata[MODE_W +: WORD_W];
  assign link_byte = s_axis_tdata[MODE_W + WORD_W +: BYTE_W];

  assign s_axis_tready = (state_q == ST_RUN) && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign rx_req.push  = accept && (mode == MODE_LINK_BYTE) && !rx_stat.full;
  assign rx_req.pop   = accept && (mode == MODE_RECV) && !rx_stat.empty;
  assign rx_req.clear = accept && (mode == MODE_LINK_RESET);
  assign tx_req.push  = accept && (mode == MODE_SEND) && !tx_stat.full;
  assign tx_req.pop   = accept && (mode == MODE_LINK_DRAIN) && !tx_stat.empty;
  assign tx_req.clear = rx_req.clear;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (rx_req.pop) begin
          state_d = ST_POP_RX;
        end else if (tx_req.pop) begin
          state_d = ST_POP_TX;
        end
      end
      ST_POP_RX, ST_POP_TX: state_d = ST_RUN;
      default:              state_d = ST_RUN;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_word_d  = out_word_q;
    out_txv_d   = out_txv_q;
    out_txb_d   = out_txb_q;
    out_ovf_d   = out_ovf_q;
    priority if (state_q == ST_POP_RX) begin
      out_valid_d = 1'b1;
      out_word_d  = RECV_OK | (WORD_W'(rx_rdata) << RECV_SHIFT);
      out_txv_d   = 1'b0;
      out_txb_d   = '0;
      out_ovf_d   = 1'b0;
    end else if (state_q == ST_POP_TX) begin
      out_valid_d = 1'b1;
      out_word_d  = '0;
      out_txv_d   = 1'b1;
      out_txb_d   = tx_rdata;
      out_ovf_d   = 1'b0;
    end else if (accept && !rx_req.pop && !tx_req.pop) begin
      out_valid_d = 1'b1;
      out_word_d  = bus_word;
      out_txv_d   = 1'b0;
      out_txb_d   = '0;
      out_ovf_d   = 1'b0;
      unique case (mode)
        MODE_INIT:       out_word_d = ident_q;
        MODE_SEND: begin
          out_word_d = tx_stat.full ? '0 : READY;
          out_ovf_d  = tx_stat.full;
        end
        MODE_CHK_TX:     out_word_d = tx_stat.full ? '0 : READY;
        MODE_CHK_RX:     out_word_d = rx_stat.empty ? '0 : READY;
        MODE_LINK_BYTE: begin
          out_word_d = '0;
          out_ovf_d  = rx_stat.full;
        end
        MODE_LINK_DRAIN: out_word_d = '0;
        MODE_LINK_RESET: out_word_d = '0;
        default:         out_word_d = bus_word;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
      ident_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && (paddr[2] == REG_IDENT)) begin
        ident_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    out_txv_q  <= out_txv_d;
    out_txb_q  <= out_txb_d;
    out_ovf_q  <= out_ovf_d;
  end

  sbfd_fifo #(.DEPTH (RX_DEPTH)) u_rx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (rx_req),
    .wdata_i (link_byte),
    .rdata_o (rx_rdata),
    .stat_o  (rx_stat)
  );

  sbfd_fifo #(.DEPTH (TX_DEPTH)) u_tx_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tx_req),
    .wdata_i (bus_word[SEND_SHIFT +: BYTE_W]),
    .rdata_o (tx_rdata),
    .stat_o  (tx_stat)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_DATA_W - WORD_W - BYTE_W - 2)'(0), out_ovf_q, out_txb_q,
                          out_txv_q, out_word_q};

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDENT) ? ident_q : '0;

endmodule
`default_nettype wire

@@ sv/sbfd_checker.sv @@
// Port-level checks for the bridge, bound to the top level.
`default_nettype none
module sbfd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [sbfd_pkg::M_DATA_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_no_take_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while result blocked");

  a_result_or_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid || !s_axis_tready)
    else $error("request neither answered nor pending");

  a_drain_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> (m_axis_tdata[31:0] == '0) && !m_axis_tdata[41])
    else $error("drained byte carries bus data or overflow");

endmodule

bind serial_bridge_fifo_device_unit sbfd_checker u_sbfd_checker (.*);
`default_nettype wire

@@ tb/tb_serial_bridge_fifo_device_unit.sv @@
// Testbench: randomised request streams against a cycle-free bridge predictor.
`default_nettype none
module tb_serial_bridge_fifo_device_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sbfd_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int RX_DEPTH    = 16;
  localparam int TX_DEPTH    = 16;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 375;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 4'hA;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 4'hF;

  typedef struct {
    logic [WORD_W-1:0] read_word;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              overflow;
  } reply_t;

  class bridge_scoreboard;
    logic [WORD_W-1:0] ident;
    logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
    logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
    int rx_head, rx_count, tx_head, tx_count;
    reply_t replies_due [$];
    int errors, checked, requests, dropped, drained, settings;

    function new();
      ident = '0;
      rx_head = 0; rx_count = 0; tx_head = 0; tx_count = 0;
      errors = 0; checked = 0; requests = 0; dropped = 0; drained = 0; settings = 0;
    endfunction

    function void set_ident(input logic [WORD_W-1:0] value);
      ident = value;
      settings++;
    endfunction

    function void note_request(input logic [S_DATA_W-1:0] req);
      logic [MODE_W-1:0] mode;
      logic [WORD_W-1:0] word;
      logic [BYTE_W-1:0] lbyte;
      reply_t r;
      mode  = req[3:0];
      word  = req[35:4];
      lbyte = req[43:36];
      r.read_word = word;
      r.tx_valid  = 1'b0;
      r.tx_byte   = '0;
      r.overflow  = 1'b0;
      requests++;
      case (mode)
        MODE_INIT: r.read_word = ident;
        MODE_RECV: begin
          if (rx_count != 0) begin
            r.read_word = RECV_OK | (WORD_W'(rx_mem[rx_head]) << RECV_SHIFT);
            rx_head = (rx_head + 1) % RX_DEPTH;
            rx_count--;
          end
        end
        MODE_SEND: begin
          if (tx_count < TX_DEPTH) begin
            tx_mem[(tx_head + tx_count) % TX_DEPTH] = word[SEND_SHIFT +: BYTE_W];
            tx_count++;
            r.read_word = READY;
          end else begin
            r.read_word = '0;
            r.overflow  = 1'b1;
            dropped++;
          end
        end
        MODE_CHK_TX: r.read_word = (tx_count < TX_DEPTH) ? READY : '0;
        MODE_CHK_RX: r.read_word = (rx_count != 0) ? READY : '0;
        MODE_LINK_BYTE: begin
          r.read_word = '0;
          if (rx_count < RX_DEPTH) begin
            rx_mem[(rx_head + rx_count) % RX_DEPTH] = lbyte;
            rx_count++;
          end else begin
            r.overflow = 1'b1;
            dropped++;
          end
        end
        MODE_LINK_DRAIN: begin
          r.read_word = '0;
          if (tx_count != 0) begin
            r.tx_byte  = tx_mem[tx_head];
            r.tx_valid = 1'b1;
            tx_head = (tx_head + 1) % TX_DEPTH;
            tx_count--;
            drained++;
          end
        end
        MODE_LINK_RESET: begin
          r.read_word = '0;
          rx_head = 0; rx_count = 0; tx_head = 0; tx_count = 0;
        end
        default: ;
      endcase
      replies_due.push_back(r);
    endfunction

    function void check_result(input logic [M_DATA_W-1:0] res);
      reply_t e;
      if (replies_due.size() == 0) begin
        $error("result %h arrived with no request pending", res);
        errors++;
        return;
      end
      e = replies_due.pop_front();
      checked++;
      if (res[31:0] !== e.read_word) begin
        $error("read_word: expected %h, got %h", e.read_word, res[31:0]);
        errors++;
      end
      if (res[32] !== e.tx_valid) begin
        $error("tx_valid: expected %b, got %b", e.tx_valid, res[32]);
        errors++;
      end
      if (res[40:33] !== e.tx_byte) begin
        $error("tx_byte: expected %h, got %h", e.tx_byte, res[40:33]);
        errors++;
      end
      if (res[41] !== e.overflow) begin
        $error("overflow: expected %b, got %b", e.overflow, res[41]);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [WORD_W-1:0]   pwdata;
  logic [WORD_W-1:0]   prdata;
  logic                pready;

  bridge_scoreboard sb = new();
  bit idling_on = 1'b1;
  bit hold_now  = 1'b0;
  int sent      = 0;
  int cycles    = 0;

  serial_bridge_fifo_device_unit #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // hold off the result side for a long stretch when asked, else stall at random while idling_on is set
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_now) begin
        hold_now = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= !(idling_on && $urandom_range(0, 99) < 24);
      end
    end
  end

  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] word,
                              input logic [BYTE_W-1:0] lbyte);
    while (idling_on && $urandom_range(0, 99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, lbyte, word, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_random(input logic [MODE_W-1:0] mode);
    send_request(mode, $urandom(), BYTE_W'($urandom()));
  endtask

  task automatic write_ident(input logic [WORD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_IDENT, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_ident(value);
  endtask

  task automatic wait_drained();
    while (sb.replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [MODE_W-1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return MODE_W'($urandom_range(0, 15));
    if (r < 14) return MODE_LINK_RESET;
    return MODE_W'($urandom_range(MODE_INIT, MODE_LINK_DRAIN));
  endfunction

  task automatic run_traffic(input int n_items);
    int goal;
    int kind;
    goal = sent + n_items;
    while (sent < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        repeat ($urandom_range(12, 20)) begin
          send_random(MODE_LINK_BYTE);
          if ($urandom_range(0, 9) == 0) send_random(MODE_CHK_RX);
        end
        repeat ($urandom_range(4, 20)) send_random(MODE_RECV);
      end else if (kind < 50) begin
        repeat ($urandom_range(12, 20)) begin
          send_random(MODE_SEND);
          if ($urandom_range(0, 9) == 0) send_random(MODE_CHK_TX);
        end
        send_random(MODE_CHK_TX);
        repeat ($urandom_range(4, 20)) send_random(MODE_LINK_DRAIN);
      end else if (kind < 90) begin
        repeat (8) send_random(pick_mode());
      end else begin
        repeat ($urandom_range(1, 4))
          send_random(MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)));
        send_random(MODE_LINK_RESET);
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_ident($urandom());
    send_request(MODE_LED_OFF, '0, '0);
    send_request(MODE_LED_ON, '1, '1);
    send_random(MODE_INIT);
    send_random(MODE_UNUSED_HI);
    send_request(MODE_RECV, '1, '0);
    send_random(MODE_CHK_RX);
    send_random(MODE_CHK_TX);
    send_random(MODE_LINK_DRAIN);
    send_request(MODE_LINK_BYTE, $urandom(), '0);
    send_request(MODE_LINK_BYTE, $urandom(), '1);
    send_random(MODE_CHK_RX);
    send_random(MODE_RECV);
    send_random(MODE_RECV);
    send_request(MODE_SEND, '0, '1);
    send_request(MODE_SEND, '1, '0);
    send_random(MODE_CHK_TX);
    send_random(MODE_LINK_DRAIN);
    send_random(MODE_LINK_DRAIN);
    send_random(MODE_LINK_BYTE);
    send_random(MODE_SEND);
    send_random(MODE_LINK_RESET);
    send_random(MODE_RECV);
    send_random(MODE_LINK_DRAIN);
    send_random(MODE_CHK_RX);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_drained();

    write_ident('1);
    run_traffic(PHASE_ITEMS);
    wait_drained();

    idling_on = 1'b0;
    write_ident('0);
    run_traffic(PHASE_ITEMS);
    wait_drained();

    idling_on = 1'b1;
    write_ident($urandom());
    hold_now = 1'b1;
    run_traffic(PHASE_ITEMS);
    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("Covered %0d requests over %0d ident settings; %0d results checked.",
             sb.requests, sb.settings, sb.checked);
    $display("Saw %0d dropped pushes and %0d bytes handed to the link.",
             sb.dropped, sb.drained);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
